// ===== rtl/kacp_pkg.sv =====
// shared types, character codes and helper functions for the knob action command parser
package kacp_pkg;

    // result event codes
    localparam logic [1:0] EvStored   = 2'd0;
    localparam logic [1:0] EvAccepted = 2'd1;
    localparam logic [1:0] EvError    = 2'd2;
    localparam logic [1:0] EvOverflow = 2'd3;

    // action codes
    localparam logic [1:0] ActCw    = 2'd0;
    localparam logic [1:0] ActCcw   = 2'd1;
    localparam logic [1:0] ActPress = 2'd2;
    localparam logic [1:0] ActRel   = 2'd3;

    // ascii codes
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpF   = 8'h46;
    localparam logic [7:0] ChLoA   = 8'h61;
    localparam logic [7:0] ChLoF   = 8'h66;
    localparam logic [7:0] ChUpC   = 8'h43;
    localparam logic [7:0] ChLoC   = 8'h63;
    localparam logic [7:0] ChUpX   = 8'h58;
    localparam logic [7:0] ChLoX   = 8'h78;
    localparam logic [7:0] ChUpP   = 8'h50;
    localparam logic [7:0] ChLoP   = 8'h70;
    localparam logic [7:0] ChUpR   = 8'h52;
    localparam logic [7:0] ChLoR   = 8'h72;
    localparam logic [7:0] ChUpK   = 8'h4B;
    localparam logic [7:0] ChLoK   = 8'h6B;
    localparam logic [7:0] ChUpM   = 8'h4D;
    localparam logic [7:0] ChLoM   = 8'h6D;

    // command line lengths and the part of the line that is ever parsed
    localparam int KeyLen   = 11;
    localparam int MediaLen = 5;
    localparam int LineMax  = 11;

    // default media usage codes
    localparam logic [7:0] VolumeUp   = 8'hE9;
    localparam logic [7:0] VolumeDown = 8'hEA;

    // first LineMax bytes of the line buffer
    typedef logic [LineMax-1:0][7:0] t_line;

    // decoded command, parser to top level
    typedef struct packed {
        logic            head_ok;   // knob, action, kind and length all good
        logic            is_key;    // keyboard command, else media
        logic [3:0]      pair_ok;   // hex pair at positions 3, 5, 7, 9 is good
        logic [3:0][7:0] pair_val;  // value of each hex pair
        logic [3:0]      knob;
        logic [1:0]      action;
    } t_cmd;

    // one hex digit: {ok, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c inside {[ChZero:ChNine]}) begin
            res = {1'b1, 4'(c - ChZero)};
        end else if (c inside {[ChLoA:ChLoF]}) begin
            res = {1'b1, 4'(c - ChLoA + 8'd10)};
        end else if (c inside {[ChUpA:ChUpF]}) begin
            res = {1'b1, 4'(c - ChUpA + 8'd10)};
        end
        return res;
    endfunction

    // two hex digits: {ok, value}
    function automatic logic [8:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0] nh;
        logic [4:0] nl;
        nh = hex_nibble(hi);
        nl = hex_nibble(lo);
        return {nh[4] & nl[4], nh[3:0], nl[3:0]};
    endfunction

endpackage

// ===== rtl/kacp_ram.sv =====
// generic single write port ram with registered read
module kacp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/kacp_parse.sv =====
// fixed-position decode of a buffered command line
module kacp_parse #(
    parameter int FILL_W     = 4,
    parameter int KNOB_COUNT = 4
) (
    input  kacp_pkg::t_line  i_buf,
    input  logic [FILL_W-1:0] i_fill,
    output kacp_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] KnobLimit = 4'(KNOB_COUNT);

    logic [kacp_pkg::LineMax-1:0][7:0] w_b;
    logic       w_digit;
    logic       w_knob_ok;
    logic       w_act_ok;
    logic [1:0] w_act;
    logic       w_kind_k;
    logic       w_kind_m;
    logic       w_len_k;
    logic       w_len_m;
    logic [8:0] w_p0;
    logic [8:0] w_p1;
    logic [8:0] w_p2;
    logic [8:0] w_p3;

    // bytes past the fill count read as zero
    always_comb begin
        for (int p = 0; p < kacp_pkg::LineMax; p++) begin
            w_b[p] = (FILL_W'(p) < i_fill) ? i_buf[p] : 8'h00;
        end
    end

    // knob digit
    assign w_digit   = w_b[0] inside {[kacp_pkg::ChZero:kacp_pkg::ChNine]};
    assign w_knob_ok = w_digit && (w_b[0][3:0] < KnobLimit);

    // action letter
    always_comb begin
        w_act_ok = 1'b1;
        w_act    = kacp_pkg::ActCw;
        case (w_b[1])
            kacp_pkg::ChUpC, kacp_pkg::ChLoC: w_act = kacp_pkg::ActCw;
            kacp_pkg::ChUpX, kacp_pkg::ChLoX: w_act = kacp_pkg::ActCcw;
            kacp_pkg::ChUpP, kacp_pkg::ChLoP: w_act = kacp_pkg::ActPress;
            kacp_pkg::ChUpR, kacp_pkg::ChLoR: w_act = kacp_pkg::ActRel;
            default: w_act_ok = 1'b0;
        endcase
    end

    // kind letter and line length
    assign w_kind_k = (w_b[2] == kacp_pkg::ChUpK) || (w_b[2] == kacp_pkg::ChLoK);
    assign w_kind_m = (w_b[2] == kacp_pkg::ChUpM) || (w_b[2] == kacp_pkg::ChLoM);
    assign w_len_k  = (i_fill == FILL_W'(kacp_pkg::KeyLen));
    assign w_len_m  = (i_fill == FILL_W'(kacp_pkg::MediaLen));

    // hex pairs
    assign w_p0 = kacp_pkg::hex_pair(w_b[3], w_b[4]);
    assign w_p1 = kacp_pkg::hex_pair(w_b[5], w_b[6]);
    assign w_p2 = kacp_pkg::hex_pair(w_b[7], w_b[8]);
    assign w_p3 = kacp_pkg::hex_pair(w_b[9], w_b[10]);

    always_comb begin
        o_cmd.head_ok  = w_knob_ok && w_act_ok &&
                         ((w_kind_k && w_len_k) || (w_kind_m && w_len_m));
        o_cmd.is_key   = w_kind_k;
        o_cmd.pair_ok  = {w_p3[8], w_p2[8], w_p1[8], w_p0[8]};
        o_cmd.pair_val = {w_p3[7:0], w_p2[7:0], w_p1[7:0], w_p0[7:0]};
        o_cmd.knob     = w_b[0][3:0];
        o_cmd.action   = w_act;
    end

endmodule

// ===== rtl/knob_action_command_parser_top.sv =====
// knob action command parser: line buffer, command decode and action table
// The result of a byte is registered and presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless the output stalls; the table is five 8-bit
// rams read and written in the same cycle (old data read); line ends add no stall.
// Reset clears the fill count, the output valid and the per-field table valid bits;
// fields never written read as zero, the media field of cw/ccw as volume up/down.
module knob_action_command_parser_top #(
    parameter int LINE_DEPTH = 16,
    parameter int KNOB_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_res,
    output logic [3:0] o_knob,
    output logic [1:0] o_action,
    output logic       o_mode,
    output logic [7:0] o_modifiers,
    output logic [7:0] o_key_one,
    output logic [7:0] o_key_two,
    output logic [7:0] o_key_three,
    output logic [7:0] o_media_key
);

    localparam int FillW      = $clog2(LINE_DEPTH);
    localparam int TableDepth = KNOB_COUNT * 4;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int NumFields  = 5;  // modifiers, key one, key two, key three, media

    // field slots
    localparam int FMod   = 0;
    localparam int FKey1  = 1;
    localparam int FKey2  = 2;
    localparam int FKey3  = 3;
    localparam int FMedia = 4;

    logic                  w_in_acc;
    logic                  w_term;
    kacp_pkg::t_cmd        w_cmd;
    logic [AddrW-1:0]      w_addr;
    logic [5:0]            w_addr_full;
    logic [3:0]            w_run_ok;
    logic                  w_accept;
    logic [NumFields-1:0]  w_we;
    logic [NumFields-1:0][7:0] w_wr_data;
    logic [NumFields-1:0][7:0] w_rd_data;
    logic [NumFields-1:0][7:0] w_old;

    kacp_pkg::t_line       r_buf;
    logic [FillW-1:0]      r_fill;
    logic [FillW-1:0]      n_fill;
    logic [TableDepth-1:0] r_fvld [NumFields];
    logic [NumFields-1:0]  r_ovld;
    logic                  r_valid;
    logic [1:0]            r_event;
    logic [1:0]            n_event;
    logic [3:0]            r_knob;
    logic [1:0]            r_action;
    logic                  r_accept;
    logic                  r_is_key;
    logic [3:0][7:0]       r_new;

    // handshake
    assign o_stall  = r_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;
    assign w_term   = (i_byte_in == kacp_pkg::ChLf) || (i_byte_in == kacp_pkg::ChCr);

    // command decode
    kacp_parse #(
        .FILL_W     (FillW),
        .KNOB_COUNT (KNOB_COUNT)
    ) u_parse (
        .i_buf  (r_buf),
        .i_fill (r_fill),
        .o_cmd  (w_cmd)
    );

    // table address knob*4+action
    assign w_addr_full = {w_cmd.knob, w_cmd.action};
    assign w_addr      = w_addr_full[AddrW-1:0];

    // pairs are committed in order until the first bad one
    assign w_run_ok[0] = w_cmd.pair_ok[0];
    assign w_run_ok[1] = w_run_ok[0] && w_cmd.pair_ok[1];
    assign w_run_ok[2] = w_run_ok[1] && w_cmd.pair_ok[2];
    assign w_run_ok[3] = w_run_ok[2] && w_cmd.pair_ok[3];

    assign w_accept = w_cmd.head_ok && (w_cmd.is_key ? w_run_ok[3] : w_run_ok[0]);

    // table field writes
    always_comb begin
        w_we[FMod]   = w_in_acc && w_term && w_cmd.head_ok && w_cmd.is_key && w_run_ok[0];
        w_we[FKey1]  = w_in_acc && w_term && w_cmd.head_ok && w_cmd.is_key && w_run_ok[1];
        w_we[FKey2]  = w_in_acc && w_term && w_cmd.head_ok && w_cmd.is_key && w_run_ok[2];
        w_we[FKey3]  = w_in_acc && w_term && w_cmd.head_ok && w_cmd.is_key && w_run_ok[3];
        w_we[FMedia] = w_in_acc && w_term && w_cmd.head_ok && !w_cmd.is_key && w_run_ok[0];
        w_wr_data[FMod]   = w_cmd.pair_val[0];
        w_wr_data[FKey1]  = w_cmd.pair_val[1];
        w_wr_data[FKey2]  = w_cmd.pair_val[2];
        w_wr_data[FKey3]  = w_cmd.pair_val[3];
        w_wr_data[FMedia] = w_cmd.pair_val[0];
    end

    // one ram per field, read of the old entry alongside the write
    for (genvar g = 0; g < NumFields; g++) begin : g_field
        kacp_ram #(
            .WIDTH (8),
            .DEPTH (TableDepth)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (w_we[g]),
            .i_wr_addr (w_addr),
            .i_wr_data (w_wr_data[g]),
            .i_rd_en   (w_in_acc),
            .i_rd_addr (w_addr),
            .o_rd_data (w_rd_data[g])
        );

        // per-entry written flags
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fvld[g] <= '0;
            end else if (w_we[g]) begin
                r_fvld[g][w_addr] <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_in_acc) begin
                r_ovld[g] <= r_fvld[g][w_addr];
            end
        end
    end

    // fill count and event
    always_comb begin
        n_fill  = r_fill;
        n_event = kacp_pkg::EvStored;
        if (w_term) begin
            n_fill  = '0;
            n_event = w_accept ? kacp_pkg::EvAccepted : kacp_pkg::EvError;
        end else if (r_fill >= FillW'(LINE_DEPTH - 1)) begin
            n_fill  = '0;
            n_event = kacp_pkg::EvOverflow;
        end else begin
            n_fill  = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_in_acc) begin
            r_fill <= n_fill;
        end
    end

    // line buffer, only the parsed positions are kept
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_term) begin
            for (int p = 0; p < kacp_pkg::LineMax; p++) begin
                if (r_fill == FillW'(p)) begin
                    r_buf[p] <= i_byte_in;
                end
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_event  <= n_event;
            r_accept <= w_term && w_accept;
            r_knob   <= (w_term && w_accept) ? w_cmd.knob : 4'd0;
            r_action <= (w_term && w_accept) ? w_cmd.action : kacp_pkg::ActCw;
            r_is_key <= w_cmd.is_key;
            r_new    <= w_cmd.pair_val;
        end
    end

    // old entry fields, defaults where never written
    always_comb begin
        for (int f = 0; f < NumFields; f++) begin
            w_old[f] = r_ovld[f] ? w_rd_data[f] : 8'h00;
        end
        if (!r_ovld[FMedia]) begin
            case (r_action)
                kacp_pkg::ActCw:  w_old[FMedia] = kacp_pkg::VolumeUp;
                kacp_pkg::ActCcw: w_old[FMedia] = kacp_pkg::VolumeDown;
                default:          w_old[FMedia] = 8'h00;
            endcase
        end
    end

    // result fields
    assign o_valid     = r_valid;
    assign o_event_res = r_event;
    assign o_knob      = r_knob;
    assign o_action    = r_action;
    assign o_mode      = r_accept && r_is_key;
    assign o_modifiers = !r_accept ? 8'h00 : (r_is_key ? r_new[0] : w_old[FMod]);
    assign o_key_one   = !r_accept ? 8'h00 : (r_is_key ? r_new[1] : w_old[FKey1]);
    assign o_key_two   = !r_accept ? 8'h00 : (r_is_key ? r_new[2] : w_old[FKey2]);
    assign o_key_three = !r_accept ? 8'h00 : (r_is_key ? r_new[3] : w_old[FKey3]);
    assign o_media_key = !r_accept ? 8'h00 : (r_is_key ? w_old[FMedia] : r_new[0]);

endmodule
